// ----- rtl/dcpm_pkg.sv -----
// Package for the duty-cycle percent meter: beat types, widths and constants.
// Used by rtl/duty_cycle_percent_meter.sv; depends on nothing else.

package dcpm_pkg;

    // Width of the captured timer value.
    localparam int TIME_BITS = 16;
    // Width of the percent value and of the constant factor 100.
    localparam int PCT_BITS  = 7;
    // Width of high*100.
    localparam int PROD_BITS = TIME_BITS + PCT_BITS;
    // Width of the running edge count.
    localparam int CNT_BITS  = 16;
    // Step counter for the serial multiply and divide.
    localparam int STEP_BITS = $clog2(PCT_BITS);

    localparam logic [PCT_BITS-1:0] PCT_FULL = PCT_BITS'(100);

    // One edge event.
    typedef struct packed {
        logic                 edge_level;
        logic [TIME_BITS-1:0] edge_time;
    } edge_t;

    // One measurement result.
    typedef struct packed {
        logic [PCT_BITS-1:0]  percent_high;
        logic [TIME_BITS-1:0] period_ticks;
        logic [TIME_BITS-1:0] high_ticks;
        logic [CNT_BITS-1:0]  edges_seen;
        logic                 period_zero;
    } result_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- rtl/duty_cycle_percent_meter.sv -----
// Duty-cycle percent meter top level: edge capture, serial multiply/divide, result register.
// Depends on rtl/dcpm_pkg.sv.

// Takes one edge beat per cycle while idle. A rising edge or an opening falling
// edge is recorded without leaving idle. A closing falling edge starts a
// measurement: a capture step, bit-serial shift-add for high*100, one
// saturation check, restoring division (one quotient bit a cycle) and a step
// to post the result. A quotient of 128 or more is caught at the saturation
// check and skips the division; a zero period skips the arithmetic. The edge
// channel stalls for the length of that sequence, and longer while a new result
// waits for the previous one to leave the output register. A result is posted
// only when the percent differs from the last reported one.

module duty_cycle_percent_meter
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              edge_valid,
    output logic              edge_stall,
    input  dcpm_pkg::edge_t   edge_data,
    output logic              result_valid,
    input  logic              result_stall,
    output dcpm_pkg::result_t result_data
);

    localparam int TB = dcpm_pkg::TIME_BITS;
    localparam int PB = dcpm_pkg::PCT_BITS;
    localparam int RB = dcpm_pkg::PROD_BITS;
    localparam int SB = dcpm_pkg::STEP_BITS;

    dcpm_pkg::state_t state_reg, state_next;

    logic [TB-1:0]                 start_fall_reg, start_fall_next;
    logic                          start_valid_reg, start_valid_next;
    logic [TB-1:0]                 rise_time_reg, rise_time_next;
    logic [PB-1:0]                 last_pct_reg, last_pct_next;
    logic [dcpm_pkg::CNT_BITS-1:0] edge_cnt_reg, edge_cnt_next;

    logic [TB-1:0]                 period_reg, period_next;
    logic [TB-1:0]                 high_reg, high_next;
    logic [dcpm_pkg::CNT_BITS-1:0] seen_reg, seen_next;
    logic                          zero_reg, zero_next;
    logic                          sat_reg, sat_next;
    logic [RB-1:0]                 prod_reg, prod_next;
    logic [SB-1:0]                 step_reg, step_next;

    logic                          res_valid_reg, res_valid_next;
    dcpm_pkg::result_t             res_reg, res_next;

    logic                          edge_take;
    logic                          res_load;
    logic [TB-1:0]                 rem;
    logic [TB:0]                   trial;
    logic [PB-1:0]                 quot;
    logic [PB-1:0]                 pct;

    assign edge_stall   = (state_reg != dcpm_pkg::ST_IDLE);
    assign edge_take    = edge_valid && !edge_stall;
    assign result_valid = res_valid_reg;
    assign result_data  = res_reg;

    // Divider datapath: remainder in the upper bits, dividend/quotient below.
    assign rem   = prod_reg[RB-1:PB];
    assign trial = {rem, prod_reg[PB-1]} - {1'b0, period_reg};
    assign quot  = prod_reg[PB-1:0];

    // Final percent with saturation and zero-period override.
    always_comb
    begin
        if (zero_reg)
            pct = '0;
        else if (sat_reg || (quot > dcpm_pkg::PCT_FULL))
            pct = dcpm_pkg::PCT_FULL;
        else
            pct = quot;
    end

    // Sequencer and datapath next state
    always_comb
    begin
        state_next       = state_reg;
        start_fall_next  = start_fall_reg;
        start_valid_next = start_valid_reg;
        rise_time_next   = rise_time_reg;
        last_pct_next    = last_pct_reg;
        edge_cnt_next    = edge_cnt_reg;
        period_next      = period_reg;
        high_next        = high_reg;
        seen_next        = seen_reg;
        zero_next        = zero_reg;
        sat_next         = sat_reg;
        prod_next        = prod_reg;
        step_next        = step_reg;
        res_load         = 1'b0;

        unique case (state_reg)
            dcpm_pkg::ST_IDLE:
            begin
                if (edge_take)
                begin
                    edge_cnt_next = edge_cnt_reg + 1'b1;
                    if (edge_data.edge_level)
                        rise_time_next = edge_data.edge_time;
                    else if (!start_valid_reg)
                    begin
                        start_fall_next  = edge_data.edge_time;
                        start_valid_next = 1'b1;
                    end
                    else
                    begin
                        // closing falling edge
                        start_valid_next = 1'b0;
                        period_next = edge_data.edge_time - start_fall_reg;
                        high_next   = edge_data.edge_time - rise_time_reg;
                        seen_next   = edge_cnt_reg + 1'b1;
                        zero_next   = (edge_data.edge_time == start_fall_reg);
                        sat_next    = 1'b0;
                        prod_next   = '0;
                        step_next   = SB'(PB - 1);
                        if (edge_data.edge_time == start_fall_reg)
                            state_next = dcpm_pkg::ST_DONE;
                        else
                            state_next = dcpm_pkg::ST_MUL;
                    end
                end
            end

            dcpm_pkg::ST_MUL:
            begin
                // one bit of the constant per cycle, MSB first
                prod_next = {prod_reg[RB-2:0], 1'b0}
                          + (dcpm_pkg::PCT_FULL[step_reg] ? RB'(high_reg) : '0);
                if (step_reg == '0)
                    state_next = dcpm_pkg::ST_CHECK;
                else
                    step_next = step_reg - 1'b1;
            end

            dcpm_pkg::ST_CHECK:
            begin
                // quotient of 2^PB or more saturates outright
                step_next = SB'(PB - 1);
                if (rem >= period_reg)
                begin
                    sat_next   = 1'b1;
                    state_next = dcpm_pkg::ST_DONE;
                end
                else
                    state_next = dcpm_pkg::ST_DIV;
            end

            dcpm_pkg::ST_DIV:
            begin
                // restoring step: shift one dividend bit in, one quotient bit out
                if (!trial[TB])
                    prod_next = {trial[TB-1:0], prod_reg[PB-2:0], 1'b1};
                else
                    prod_next = {prod_reg[RB-2:0], 1'b0};
                if (step_reg == '0)
                    state_next = dcpm_pkg::ST_DONE;
                else
                    step_next = step_reg - 1'b1;
            end

            dcpm_pkg::ST_DONE:
            begin
                if (pct == last_pct_reg)
                    state_next = dcpm_pkg::ST_IDLE;
                else if (!res_valid_reg || !result_stall)
                begin
                    res_load      = 1'b1;
                    last_pct_next = pct;
                    state_next    = dcpm_pkg::ST_IDLE;
                end
            end

            default:
                state_next = dcpm_pkg::ST_IDLE;
        endcase
    end

    // Output register
    always_comb
    begin
        res_next              = res_reg;
        res_valid_next        = res_valid_reg && result_stall;
        res_next.percent_high = pct;
        res_next.period_ticks = period_reg;
        res_next.high_ticks   = high_reg;
        res_next.edges_seen   = seen_reg;
        res_next.period_zero  = zero_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else
            res_next = res_reg;
    end

    // Control and measurement state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= dcpm_pkg::ST_IDLE;
            start_fall_reg  <= '0;
            start_valid_reg <= 1'b0;
            rise_time_reg   <= '0;
            last_pct_reg    <= '0;
            edge_cnt_reg    <= '0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            start_fall_reg  <= start_fall_next;
            start_valid_reg <= start_valid_next;
            rise_time_reg   <= rise_time_next;
            last_pct_reg    <= last_pct_next;
            edge_cnt_reg    <= edge_cnt_next;
            res_valid_reg   <= res_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        period_reg <= period_next;
        high_reg   <= high_next;
        seen_reg   <= seen_next;
        zero_reg   <= zero_next;
        sat_reg    <= sat_next;
        prod_reg   <= prod_next;
        step_reg   <= step_next;
        res_reg    <= res_next;
    end

    // Assertions
    a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.percent_high <= dcpm_pkg::PCT_FULL))
        else $error("percent above full scale");

    a_zero_pct: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.period_zero) |-> (result_data.percent_high == '0))
        else $error("zero period with nonzero percent");

    a_new_pct: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> (result_data.percent_high != $past(last_pct_reg)))
        else $error("result posted with unchanged percent");

    a_mul_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dcpm_pkg::ST_MUL) |=>
            (state_reg == dcpm_pkg::ST_MUL || state_reg == dcpm_pkg::ST_CHECK))
        else $error("multiply sequence broken");

endmodule
